// ===== src/wdcvs_pkg.sv =====
// Package: shared types, codes and constants of the WAV data chunk volume scaler.
package wdcvs_pkg;

   localparam logic [31:0] TAG_RIFF      = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE      = 32'h5741_5645;
   localparam logic [31:0] TAG_DATA      = 32'h6461_7461;
   localparam logic [31:0] MIN_FILE_LEN  = 32'd44;
   localparam logic [32:0] FIRST_CHUNK   = 33'd12;
   localparam logic [32:0] CHUNK_HDR_LEN = 33'd8;

   // Reciprocal of ten: floor(m * RECIP_10 / 2**RECIP_SHIFT) == m / 10 for m < 2**23
   localparam logic [22:0] RECIP_10    = 23'd6710887;
   localparam int          RECIP_SHIFT = 26;

   localparam logic [2:0] ST_SAMPLE     = 3'd0;
   localparam logic [2:0] ST_DONE       = 3'd1;
   localparam logic [2:0] ST_BAD_HEADER = 3'd2;
   localparam logic [2:0] ST_OVERRUN    = 3'd3;
   localparam logic [2:0] ST_NO_DATA    = 3'd4;

   localparam logic CSR_FILE_LENGTH = 1'b0;
   localparam logic CSR_VOLUME      = 1'b1;

   localparam logic [31:0] FILE_LENGTH_RESET = 32'd0;
   localparam logic [7:0]  VOLUME_RESET      = 8'd10;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_CHUNK_HDR,
      PH_SKIP,
      PH_DATA_LO,
      PH_DATA_HI,
      PH_FINISHED
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_of_file;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic [2:0]         status;
      logic               last;
   } rsp_type;

   // One parse step's results: an optional sample followed by an optional status
   typedef struct packed {
      logic               has_sample;
      logic signed [15:0] raw;
      logic               has_status;
      logic [2:0]         status;
   } item_type;

   function automatic logic [7:0] tag_byte(logic [31:0] tag, logic [1:0] idx);
      logic [7:0] b;
      case (idx)
         2'd0:    b = tag[31:24];
         2'd1:    b = tag[23:16];
         2'd2:    b = tag[15:8];
         default: b = tag[7:0];
      endcase
      return b;
   endfunction

endpackage

// ===== src/wdcvs_parser.sv =====
// Parser: header check and chunk walk, one byte per request, registered result item.
module wdcvs_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic [31:0]        file_length,
   input  logic               req_valid,
   output logic               req_ready,
   input  wdcvs_pkg::req_type req_data,
   output logic               item_valid,
   input  logic               item_ready,
   output wdcvs_pkg::item_type item
);
   import wdcvs_pkg::*;

   phase_type   phase_ff, phase_in, phase_cur;
   logic [32:0] pos_ff, pos_in, pos_cur;
   logic [31:0] tag_ff, tag_in, tag_cur;
   logic [31:0] len_ff, len_in, len_cur;
   logic [32:0] left_ff, left_in, left_cur, left_dec;
   logic [7:0]  low_ff, low_in, low_cur;
   logic        match_ff, match_in, match_cur;
   logic        item_valid_ff, item_valid_in;
   item_type    item_ff, item_in;
   logic        accept;
   logic [7:0]  b;
   logic [34:0] end_sum, next_sum;
   logic        pad;

   assign req_ready  = !item_valid_ff || item_ready;
   assign accept     = req_valid && req_ready;
   assign item_valid = item_valid_ff;
   assign item       = item_ff;
   assign b          = req_data.data_byte;

   always_comb begin
      // Restart the parse before a byte that marks the start of a file
      if (req_data.first_of_file) begin
         phase_cur = PH_HEADER;
         pos_cur   = '0;
         tag_cur   = '0;
         len_cur   = '0;
         left_cur  = '0;
         low_cur   = '0;
         match_cur = 1'b1;
      end else begin
         phase_cur = phase_ff;
         pos_cur   = pos_ff;
         tag_cur   = tag_ff;
         len_cur   = len_ff;
         left_cur  = left_ff;
         low_cur   = low_ff;
         match_cur = match_ff;
      end

      phase_in = phase_cur;
      pos_in   = pos_cur;
      tag_in   = tag_cur;
      len_in   = len_cur;
      left_in  = left_cur;
      low_in   = low_cur;
      match_in = match_cur;
      item_in  = '0;
      left_dec = left_cur - 33'd1;

      if (phase_cur == PH_CHUNK_HDR) begin
         if (left_cur > 33'd4) tag_in = {tag_cur[23:0], b};
         else                  len_in = {b, len_cur[31:8]};
      end
      pad      = len_in[0];
      end_sum  = {2'b00, pos_cur} + {3'b000, len_in} + 35'd1;
      next_sum = {2'b00, pos_cur} + {3'b000, len_in} + 35'd1
                 + {2'b00, CHUNK_HDR_LEN} + {34'd0, pad};

      if (phase_cur != PH_FINISHED) pos_in = pos_cur + 33'd1;

      case (phase_cur)
         PH_HEADER: begin
            if (pos_cur < 33'd4 && b != tag_byte(TAG_RIFF, pos_cur[1:0]))
               match_in = 1'b0;
            if (pos_cur >= 33'd8 && pos_cur < FIRST_CHUNK
                && b != tag_byte(TAG_WAVE, pos_cur[1:0]))
               match_in = 1'b0;
            if (pos_cur == 33'd0 && file_length < MIN_FILE_LEN) begin
               phase_in           = PH_FINISHED;
               item_in.has_status = 1'b1;
               item_in.status     = ST_BAD_HEADER;
            end else if (pos_cur + 33'd1 >= FIRST_CHUNK) begin
               if (!match_in) begin
                  phase_in           = PH_FINISHED;
                  item_in.has_status = 1'b1;
                  item_in.status     = ST_BAD_HEADER;
               end else begin
                  phase_in = PH_CHUNK_HDR;
                  left_in  = CHUNK_HDR_LEN;
               end
            end
         end
         PH_CHUNK_HDR: begin
            left_in = left_dec;
            if (left_dec == '0) begin
               if (end_sum > {3'b000, file_length}) begin
                  phase_in           = PH_FINISHED;
                  item_in.has_status = 1'b1;
                  item_in.status     = ST_OVERRUN;
               end else if (tag_in == TAG_DATA) begin
                  if (len_in[31:1] == '0) begin
                     phase_in           = PH_FINISHED;
                     item_in.has_status = 1'b1;
                     item_in.status     = ST_DONE;
                  end else begin
                     phase_in = PH_DATA_LO;
                     left_in  = {1'b0, len_in[31:1], 1'b0};
                  end
               end else if (next_sum > {3'b000, file_length}) begin
                  phase_in           = PH_FINISHED;
                  item_in.has_status = 1'b1;
                  item_in.status     = ST_NO_DATA;
               end else if (len_in == '0) begin
                  left_in = CHUNK_HDR_LEN;
               end else begin
                  phase_in = PH_SKIP;
                  left_in  = {1'b0, len_in} + {32'd0, pad};
               end
            end
         end
         PH_SKIP: begin
            left_in = left_dec;
            if (left_dec == '0) begin
               phase_in = PH_CHUNK_HDR;
               left_in  = CHUNK_HDR_LEN;
            end
         end
         PH_DATA_LO: begin
            low_in   = b;
            left_in  = left_dec;
            phase_in = PH_DATA_HI;
         end
         PH_DATA_HI: begin
            item_in.has_sample = 1'b1;
            item_in.raw        = {b, low_cur};
            left_in            = left_dec;
            if (left_dec == '0) begin
               phase_in           = PH_FINISHED;
               item_in.has_status = 1'b1;
               item_in.status     = ST_DONE;
            end else begin
               phase_in = PH_DATA_LO;
            end
         end
         default: phase_in = PH_FINISHED;
      endcase

      // Drop steps that produce nothing
      if (accept) item_valid_in = item_in.has_sample || item_in.has_status;
      else        item_valid_in = item_valid_ff && !item_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HEADER;
         pos_ff        <= '0;
         tag_ff        <= '0;
         len_ff        <= '0;
         left_ff       <= '0;
         low_ff        <= '0;
         match_ff      <= 1'b1;
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         if (accept) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            tag_ff   <= tag_in;
            len_ff   <= len_in;
            left_ff  <= left_in;
            low_ff   <= low_in;
            match_ff <= match_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) item_ff <= item_in;
   end

endmodule

// ===== src/wdcvs_scaler.sv =====
// Scaler: volume multiply, divide by ten, saturate, and result output register.
module wdcvs_scaler (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          volume,
   input  logic                item_valid,
   output logic                item_ready,
   input  wdcvs_pkg::item_type item,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output wdcvs_pkg::rsp_type  rsp_data
);
   import wdcvs_pkg::*;

   logic               b_valid_ff, c_valid_ff, o_valid_ff;
   logic               b_take, c_take, o_take;
   logic               b_has_smp_ff, c_has_smp_ff, o_has_smp_ff;
   logic               b_has_st_ff, c_has_st_ff, o_has_st_ff;
   logic [2:0]         b_status_ff, c_status_ff, o_status_ff;
   logic               b_neg_ff, b_neg_in, c_neg_ff;
   logic [22:0]        b_mag_ff, b_mag_in;
   logic [19:0]        c_quot_ff, c_quot_in;
   logic signed [15:0] o_sample_ff, o_sample_in;
   logic signed [24:0] product;
   logic [45:0]        recip_prod;
   logic               o_pair;

   assign o_pair     = o_has_smp_ff && o_has_st_ff;
   assign o_take     = !o_valid_ff || (rsp_ready && !o_pair);
   assign c_take     = !c_valid_ff || o_take;
   assign b_take     = !b_valid_ff || c_take;
   assign item_ready = b_take;

   always_comb begin
      product  = 25'(signed'(item.raw)) * 25'(signed'({1'b0, volume}));
      b_neg_in = product[24];
      b_mag_in = product[24] ? 23'(-product) : product[22:0];

      recip_prod = {23'd0, b_mag_ff} * {23'd0, RECIP_10};
      c_quot_in  = recip_prod[45:RECIP_SHIFT];

      // Saturate to 16 bits; the quotient was truncated toward zero
      if (c_neg_ff) begin
         if (c_quot_ff > 20'd32768) o_sample_in = -16'sd32768;
         else o_sample_in = 16'(-signed'({1'b0, c_quot_ff}));
      end else begin
         if (c_quot_ff > 20'd32767) o_sample_in = 16'sd32767;
         else                       o_sample_in = signed'(c_quot_ff[15:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (b_take) b_valid_ff <= item_valid;
         if (c_take) c_valid_ff <= b_valid_ff;
         if (o_take) o_valid_ff <= c_valid_ff;
         else if (rsp_ready && o_pair) o_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (b_take) begin
         b_has_smp_ff <= item.has_sample;
         b_has_st_ff  <= item.has_status;
         b_status_ff  <= item.status;
         b_neg_ff     <= b_neg_in;
         b_mag_ff     <= b_mag_in;
      end
      if (c_take) begin
         c_has_smp_ff <= b_has_smp_ff;
         c_has_st_ff  <= b_has_st_ff;
         c_status_ff  <= b_status_ff;
         c_neg_ff     <= b_neg_ff;
         c_quot_ff    <= c_quot_in;
      end
      if (o_take) begin
         o_has_smp_ff <= c_has_smp_ff;
         o_has_st_ff  <= c_has_st_ff;
         o_status_ff  <= c_status_ff;
         o_sample_ff  <= o_sample_in;
      end else if (rsp_ready && o_pair) begin
         // Sample went out; hold the status until it is taken
         o_has_smp_ff <= 1'b0;
      end
   end

   assign rsp_valid       = o_valid_ff;
   assign rsp_data.sample = o_has_smp_ff ? o_sample_ff : 16'sd0;
   assign rsp_data.status = o_has_smp_ff ? ST_SAMPLE : o_status_ff;
   assign rsp_data.last   = !o_has_smp_ff;

endmodule

// ===== src/wav_data_chunk_volume_scaler.sv =====
// Top level: WAV data chunk parser with volume scaling of 16-bit samples.
// Path from the accepting edge to rsp_valid: parse, multiply, divide and saturate registers in turn.
// Throughput: one byte per cycle while rsp_ready holds; a step that yields the last sample and done
// holds the output register, and stalls the bytes behind it, until both results are delivered.
// Reset (synchronous): parse restarts at byte zero, file_length 0, volume 10,
// pipeline empty.
module wav_data_chunk_volume_scaler (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  wdcvs_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output wdcvs_pkg::rsp_type rsp_data,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [31:0]        csr_write_data
);
   import wdcvs_pkg::*;

   logic [31:0] file_length_ff;
   logic [7:0]  volume_ff;
   logic        item_valid;
   logic        item_ready;
   item_type    item;

   always_ff @(posedge clock) begin
      if (reset) begin
         file_length_ff <= FILE_LENGTH_RESET;
         volume_ff      <= VOLUME_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_FILE_LENGTH: file_length_ff <= csr_write_data;
            CSR_VOLUME:      volume_ff      <= csr_write_data[7:0];
            default:         ;
         endcase
      end
   end

   wdcvs_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .file_length (file_length_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .item_valid  (item_valid),
      .item_ready  (item_ready),
      .item        (item)
   );

   wdcvs_scaler u_scaler (
      .clock      (clock),
      .reset      (reset),
      .volume     (volume_ff),
      .item_valid (item_valid),
      .item_ready (item_ready),
      .item       (item),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
